/* rtl/charger_led_level_decoder_macros.svh */
// Assertion macros for the charger LED level decoder checker.
`ifndef CHARGER_LED_LEVEL_DECODER_MACROS_SVH
`define CHARGER_LED_LEVEL_DECODER_MACROS_SVH

// Concurrent assertion on clk, disabled while arst_n is low.
`define CLD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Concurrent assertion on clk that also holds during reset.
`define CLD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/cld_pkg.sv */
// Types and constants of the charger LED level decoder.
`timescale 1ns / 1ps
`default_nettype none
package cld_pkg;

	localparam int unsigned INTERVAL_W = 24;
	localparam int unsigned LOW_W      = 6;
	localparam int unsigned WAIT_W     = 8;
	localparam int unsigned PERCENT_W  = 7;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [INTERVAL_W-1:0] MEASURE_INTERVAL_RST = 24'd100000;
	localparam logic [LOW_W-1:0]      LOW_COUNT_LIMIT_RST  = 6'd56;
	localparam logic [LOW_W-1:0]      EMPTY_THRESHOLD_RST  = 6'd52;
	localparam logic [WAIT_W-1:0]     FIRST_WAIT_RST       = 8'd16;
	localparam logic [WAIT_W-1:0]     SECOND_WAIT_RST      = 8'd11;

	localparam logic [PERCENT_W-1:0] PCT_EMPTY   = 7'd0;
	localparam logic [PERCENT_W-1:0] PCT_QUARTER = 7'd25;
	localparam logic [PERCENT_W-1:0] PCT_HALF    = 7'd50;
	localparam logic [PERCENT_W-1:0] PCT_THREEQ  = 7'd75;
	localparam logic [PERCENT_W-1:0] PCT_FULL    = 7'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MEASURE_INTERVAL = 3'd0,
		CFG_LOW_COUNT_LIMIT  = 3'd1,
		CFG_EMPTY_THRESHOLD  = 3'd2,
		CFG_FIRST_WAIT       = 3'd3,
		CFG_SECOND_WAIT      = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_SYNC1  = 4'd1,
		PH_PAUSE  = 4'd2,
		PH_SYNC2  = 4'd3,
		PH_LOWCNT = 4'd4,
		PH_WAIT1  = 4'd5,
		PH_ACHK2  = 4'd6,
		PH_BCHK2  = 4'd7,
		PH_WAIT2  = 4'd8,
		PH_CCHK2  = 4'd9
	} phase_t;

	typedef struct packed {
		logic [INTERVAL_W-1:0] measure_interval;
		logic [LOW_W-1:0]      low_count_limit;
		logic [LOW_W-1:0]      empty_threshold;
		logic [WAIT_W-1:0]     first_wait;
		logic [WAIT_W-1:0]     second_wait;
	} cld_cfg_t;

	typedef struct packed {
		logic                 valid;
		logic [PERCENT_W-1:0] percent;
	} cld_result_t;

endpackage
`default_nettype wire

/* rtl/cld_ifs.sv */
// Handshake channel interfaces of the charger LED level decoder.
`timescale 1ns / 1ps
`default_nettype none
interface cld_pins_if;
	logic valid;
	logic ready;
	logic level_pin_a;
	logic level_pin_b;

	modport source (output valid, output level_pin_a, output level_pin_b, input ready);
	modport sink (input valid, input level_pin_a, input level_pin_b, output ready);
endinterface

interface cld_level_if;
	import cld_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [PERCENT_W-1:0] level_percent;

	modport source (output valid, output level_percent, input ready);
	modport sink (input valid, input level_percent, output ready);
endinterface

interface cld_cfg_if;
	import cld_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/cld_fsm.sv */
// Measurement sequencer: interval timer, pin sync, low count and level checks.
`timescale 1ns / 1ps
`default_nettype none
module cld_fsm (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 accept,
	input  wire logic                 pin_a,
	input  wire logic                 pin_b,
	input  wire cld_pkg::cld_cfg_t    cfg,
	output cld_pkg::cld_result_t      res
);
	import cld_pkg::*;

	phase_t                phase_q, phase_d;
	logic [INTERVAL_W-1:0] interval_q, interval_d;
	logic [LOW_W-1:0]      low_q, low_d;
	logic [WAIT_W-1:0]     wait_q, wait_d;
	logic [WAIT_W-1:0]     wait_inc;
	logic [INTERVAL_W-1:0] interval_inc;
	logic                  low_more;

	assign wait_inc     = (wait_q != {WAIT_W{1'b1}}) ? wait_q + 1'b1 : wait_q;
	assign interval_inc = (interval_q != {INTERVAL_W{1'b1}}) ? interval_q + 1'b1 : interval_q;
	assign low_more     = !pin_a && (low_q < cfg.low_count_limit);

	always_comb begin
		phase_d     = phase_q;
		interval_d  = interval_inc;
		low_d       = low_q;
		wait_d      = wait_q;
		res.valid   = 1'b0;
		res.percent = PCT_EMPTY;
		if (phase_q == PH_IDLE && interval_q > cfg.measure_interval) begin
			// The start tick samples no pins.
			interval_d = '0;
			low_d      = '0;
			phase_d    = PH_SYNC1;
		end else begin
			case (phase_q)
				PH_IDLE: begin
				end
				PH_SYNC1: begin
					if (!pin_a) phase_d = PH_PAUSE;
				end
				PH_PAUSE: begin
					phase_d = PH_SYNC2;
				end
				PH_SYNC2, PH_LOWCNT: begin
					if (phase_q == PH_SYNC2 && pin_a) begin
						phase_d = PH_SYNC2;
					end else if (low_more) begin
						low_d   = low_q + 1'b1;
						phase_d = PH_LOWCNT;
					end else if (low_q > cfg.empty_threshold) begin
						res.valid   = 1'b1;
						res.percent = PCT_EMPTY;
						phase_d     = PH_IDLE;
					end else begin
						wait_d  = '0;
						phase_d = PH_WAIT1;
					end
				end
				PH_WAIT1: begin
					wait_d = wait_inc;
					if (wait_inc >= cfg.first_wait) begin
						if (pin_a) begin
							phase_d = PH_ACHK2;
						end else if (!pin_b) begin
							phase_d = PH_BCHK2;
						end else begin
							wait_d  = '0;
							phase_d = PH_WAIT2;
						end
					end
				end
				PH_ACHK2: begin
					if (pin_a) begin
						res.valid   = 1'b1;
						res.percent = PCT_FULL;
						phase_d     = PH_IDLE;
					end else if (!pin_b) begin
						phase_d = PH_BCHK2;
					end else begin
						wait_d  = '0;
						phase_d = PH_WAIT2;
					end
				end
				PH_BCHK2: begin
					if (!pin_b) begin
						res.valid   = 1'b1;
						res.percent = PCT_QUARTER;
						phase_d     = PH_IDLE;
					end else begin
						wait_d  = '0;
						phase_d = PH_WAIT2;
					end
				end
				PH_WAIT2: begin
					wait_d = wait_inc;
					if (wait_inc >= cfg.second_wait) begin
						if (pin_b) begin
							phase_d = PH_CCHK2;
						end else begin
							res.valid   = 1'b1;
							res.percent = PCT_HALF;
							phase_d     = PH_IDLE;
						end
					end
				end
				PH_CCHK2: begin
					res.valid   = 1'b1;
					res.percent = pin_b ? PCT_THREEQ : PCT_HALF;
					phase_d     = PH_IDLE;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			interval_q <= '0;
			low_q      <= '0;
			wait_q     <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			interval_q <= interval_d;
			low_q      <= low_d;
			wait_q     <= wait_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/charger_led_level_decoder.sv */
// Top level of the charger LED level decoder: config registers and result register.
// A result word is valid in the cycle after the pin word that completes it.
// Throughput: one pin word per cycle; a held result stalls input only while unread.
// Each word updates the sequencer state through one level of logic into its registers.
// Reset clears the sequencer to idle, counters to zero and config registers to their defaults.
// Configuration writes are always accepted and take effect on the next word.
`timescale 1ns / 1ps
`default_nettype none
module charger_led_level_decoder (
	input  wire logic clk,
	input  wire logic arst_n,
	cld_pins_if.sink  pins,
	cld_level_if.source level,
	cld_cfg_if.sink   cfg
);
	import cld_pkg::*;

	cld_cfg_t              cfg_q;
	cld_result_t           res;
	logic                  accept;
	logic                  out_valid_q;
	logic [PERCENT_W-1:0]  percent_q;

	assign pins.ready = !out_valid_q || level.ready;
	assign accept     = pins.valid && pins.ready;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.measure_interval <= MEASURE_INTERVAL_RST;
			cfg_q.low_count_limit  <= LOW_COUNT_LIMIT_RST;
			cfg_q.empty_threshold  <= EMPTY_THRESHOLD_RST;
			cfg_q.first_wait       <= FIRST_WAIT_RST;
			cfg_q.second_wait      <= SECOND_WAIT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MEASURE_INTERVAL: cfg_q.measure_interval <= cfg.data[INTERVAL_W-1:0];
				CFG_LOW_COUNT_LIMIT:  cfg_q.low_count_limit  <= cfg.data[LOW_W-1:0];
				CFG_EMPTY_THRESHOLD:  cfg_q.empty_threshold  <= cfg.data[LOW_W-1:0];
				CFG_FIRST_WAIT:       cfg_q.first_wait       <= cfg.data[WAIT_W-1:0];
				CFG_SECOND_WAIT:      cfg_q.second_wait      <= cfg.data[WAIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	cld_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.pin_a  (pins.level_pin_a),
		.pin_b  (pins.level_pin_b),
		.cfg    (cfg_q),
		.res    (res)
	);

	// The result register refills in the same cycle that its word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (level.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res.valid) begin
			percent_q <= res.percent;
		end
	end

	assign level.valid         = out_valid_q;
	assign level.level_percent = percent_q;

endmodule
`default_nettype wire

/* rtl/cld_checker.sv */
// Port-level assertions for the charger LED level decoder, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
`include "charger_led_level_decoder_macros.svh"
module cld_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          pins_valid,
	input wire logic                          pins_ready,
	input wire logic                          level_valid,
	input wire logic                          level_ready,
	input wire logic [cld_pkg::PERCENT_W-1:0] level_percent,
	input wire logic                          cfg_ready
);
	import cld_pkg::*;

	`CLD_ASSERT(a_percent_legal, level_valid |-> (level_percent == PCT_EMPTY || level_percent == PCT_QUARTER || level_percent == PCT_HALF || level_percent == PCT_THREEQ || level_percent == PCT_FULL), "level word is not a legal percentage")
	`CLD_ASSERT(a_result_holds, (level_valid && !level_ready) |=> (level_valid && $stable(level_percent)), "stalled level word changed")
	`CLD_ASSERT(a_result_from_word, $rose(level_valid) |-> $past(pins_valid && pins_ready), "level word appeared without an accepted pin word")
	`CLD_ASSERT(a_stall_backpressure, (level_valid && !level_ready) |-> !pins_ready, "pin word taken while a result is stalled")
	`CLD_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "configuration channel not ready")

endmodule

bind charger_led_level_decoder cld_checker u_cld_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.pins_valid    (pins.valid),
	.pins_ready    (pins.ready),
	.level_valid   (level.valid),
	.level_ready   (level.ready),
	.level_percent (level.level_percent),
	.cfg_ready     (cfg.ready)
);
`default_nettype wire
